FILE: src/itma_pkg.sv
// Shared constants for the interval timer with per-mark moving average.
`timescale 1ns / 1ps

package itma_pkg;

    localparam int WINDOW_DEF = 64;
    localparam int MARKS_DEF  = 16;

    localparam int ID_W   = 4;
    localparam int TS_W   = 48;
    localparam int DUR_W  = 32;
    localparam int AVG_W  = 40;
    localparam int SAMP_W = 7;
    localparam int FRAC_W = 8;

endpackage

FILE: src/itma_div.sv
// Restoring divider that produces one quotient bit per clock cycle.
`timescale 1ns / 1ps

module itma_div #(
    parameter int DW = 46,
    parameter int VW = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CNTW = $clog2(DW + 1);

    logic [DW-1:0]   work_reg;
    logic [VW-1:0]   rem_reg;
    logic [VW-1:0]   dsor_reg;
    logic [CNTW-1:0] count_reg;
    logic            run_reg;
    logic            done_reg;

    logic [VW:0]   rem_shift;
    logic [VW:0]   rem_diff;
    logic          fits;
    logic [VW-1:0] rem_next;
    logic [DW-1:0] work_next;

    // The partial remainder stays below the divisor, so both branches fit in VW bits.
    always_comb
    begin
        rem_shift = {rem_reg, work_reg[DW-1]};
        rem_diff  = rem_shift - {1'b0, dsor_reg};
        fits      = (rem_shift >= {1'b0, dsor_reg});
        rem_next  = fits ? rem_diff[VW-1:0] : rem_shift[VW-1:0];
        work_next = {work_reg[DW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg   <= 1'b1;
                count_reg <= CNTW'(DW);
            end
            else if (run_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == CNTW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= dividend;
            rem_reg  <= '0;
            dsor_reg <= divisor;
        end
        else if (run_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

FILE: src/interval_timer_moving_average_unit.sv
// Top level: mark table, sample window memory, sequencer and mean divider.
//
// Usage: a request is taken at a rising edge where start is high and busy is
// low. It carries req_type (0 begin, 1 end), mark_id and timestamp_ns. Begin
// opens a closed mark and records the time; end on an open mark closes it,
// stores the saturated duration in the mark's window and updates the sum.
// Exactly one result follows each request: done is high for one cycle while
// accepted, duration_ns, average_q8 and samples_in_window hold the result.
// The receiver cannot stall; results are simply presented for that cycle.
// For an accepted end the request passes through table lookup, window read
// and update, a step that starts the divider, the mean division at one
// quotient bit per cycle over 32 + log2(WINDOW) + 8 = 46 bits with WINDOW = 64,
// the divider's finishing step and the strobe. Begin and ignored requests
// skip the update. The bit-serial divider takes most of the time, and
// busy stays high throughout, so one request is handled at a time; busy
// falls in the strobe cycle, so a new request can be taken from then on.
// Reset clears every mark to closed with an empty window; the sample memory
// and start times need no clearing because they are only read once written.
// Mark indices at or above MARKS are ignored and report all zero fields.
`timescale 1ns / 1ps

module interval_timer_moving_average_unit #(
    parameter int WINDOW = itma_pkg::WINDOW_DEF,
    parameter int MARKS  = itma_pkg::MARKS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          req_type,
    input  logic [itma_pkg::ID_W-1:0]     mark_id,
    input  logic [itma_pkg::TS_W-1:0]     timestamp_ns,
    output logic                          done,
    output logic                          accepted,
    output logic [itma_pkg::DUR_W-1:0]    duration_ns,
    output logic [itma_pkg::AVG_W-1:0]    average_q8,
    output logic [itma_pkg::SAMP_W-1:0]   samples_in_window
);

    import itma_pkg::*;

    // Only sixteen marks can be addressed by the request field.
    localparam int MARKS_USED = (MARKS < (1 << ID_W)) ? MARKS : (1 << ID_W);
    localparam int MB   = (MARKS_USED > 1) ? $clog2(MARKS_USED) : 1;
    localparam int SB   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW   = $clog2(WINDOW + 1);
    localparam int SUMW = DUR_W + $clog2(WINDOW);
    localparam int DIVW = SUMW + FRAC_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOAD  = 6'b000010,
        S_CALC  = 6'b000100,
        S_UPD   = 6'b001000,
        S_START = 6'b010000,
        S_DIV   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Per-mark table.
    logic             mark_open_reg  [MARKS_USED];
    logic [TS_W-1:0]  start_time_reg [MARKS_USED];
    logic [SB-1:0]    write_slot_reg [MARKS_USED];
    logic [CW-1:0]    count_arr_reg  [MARKS_USED];
    logic [SUMW-1:0]  sum_arr_reg    [MARKS_USED];

    logic [DUR_W-1:0] window_mem [MARKS_USED][WINDOW];
    logic [DUR_W-1:0] old_sample_reg;

    // Captured request and working copy of the selected mark.
    logic             is_end_reg;
    logic [ID_W-1:0]  mark_reg;
    logic [TS_W-1:0]  ts_reg;
    logic             valid_mark_reg;
    logic             open_reg;
    logic [TS_W-1:0]  start_reg;
    logic [SB-1:0]    slot_reg;
    logic [CW-1:0]    cnt_reg;
    logic [SUMW-1:0]  sum_reg;
    logic [DUR_W-1:0] dur_reg;
    logic             acc_reg;

    logic             done_reg;
    logic             out_acc_reg;
    logic [DUR_W-1:0] out_dur_reg;
    logic [AVG_W-1:0] out_avg_reg;
    logic [SAMP_W-1:0] out_samp_reg;

    logic [MB-1:0]    mark_idx;
    logic             mark_ok;
    logic [TS_W-1:0]  diff;
    logic [DUR_W-1:0] dur_sat;
    logic             full;
    logic             do_end;
    logic             do_begin;
    logic [SUMW-1:0]  sum_new;
    logic [CW-1:0]    cnt_new;
    logic [SB-1:0]    slot_new;

    logic             div_start;
    logic             div_done;
    logic [DIVW-1:0]  div_quot;

    assign mark_idx = mark_reg[MB-1:0];
    assign mark_ok  = (32'(mark_reg) < MARKS);
    assign full     = (cnt_reg == CW'(WINDOW));
    assign do_end   = valid_mark_reg && is_end_reg && open_reg;
    assign do_begin = valid_mark_reg && !is_end_reg && !open_reg;
    assign div_start = (state_reg == S_START);

    always_comb
    begin
        diff     = ts_reg - start_reg;
        dur_sat  = (diff[TS_W-1:DUR_W] != '0) ? '1 : diff[DUR_W-1:0];
        sum_new  = sum_reg + SUMW'(dur_reg);
        cnt_new  = full ? cnt_reg : cnt_reg + 1'b1;
        slot_new = (slot_reg == SB'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_LOAD;
            end
            S_LOAD:  state_next = S_CALC;
            S_CALC:  state_next = do_end ? S_UPD : S_START;
            S_UPD:   state_next = S_START;
            S_START: state_next = S_DIV;
            S_DIV:
            begin
                if (div_done)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            for (int i = 0; i < MARKS_USED; i++)
            begin
                mark_open_reg[i]  <= 1'b0;
                write_slot_reg[i] <= '0;
                count_arr_reg[i]  <= '0;
                sum_arr_reg[i]    <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_DIV) && div_done;
            if (state_reg == S_CALC && do_begin)
                mark_open_reg[mark_idx] <= 1'b1;
            if (state_reg == S_UPD)
            begin
                mark_open_reg[mark_idx]  <= 1'b0;
                write_slot_reg[mark_idx] <= slot_new;
                count_arr_reg[mark_idx]  <= cnt_new;
                sum_arr_reg[mark_idx]    <= sum_new;
            end
        end
    end

    // Working registers and start times carry payload only.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    is_end_reg <= req_type;
                    mark_reg   <= mark_id;
                    ts_reg     <= timestamp_ns;
                end
            end
            S_LOAD:
            begin
                valid_mark_reg <= mark_ok;
                open_reg       <= mark_ok ? mark_open_reg[mark_idx] : 1'b0;
                start_reg      <= start_time_reg[mark_idx];
                slot_reg       <= write_slot_reg[mark_idx];
                cnt_reg        <= mark_ok ? count_arr_reg[mark_idx] : '0;
                sum_reg        <= mark_ok ? sum_arr_reg[mark_idx] : '0;
                acc_reg        <= 1'b0;
                dur_reg        <= '0;
            end
            S_CALC:
            begin
                if (do_begin)
                begin
                    start_time_reg[mark_idx] <= ts_reg;
                    acc_reg <= 1'b1;
                end
                if (do_end)
                begin
                    dur_reg <= dur_sat;
                    acc_reg <= 1'b1;
                    // Once the window is full the oldest sample leaves the sum.
                    if (full)
                        sum_reg <= sum_reg - SUMW'(old_sample_reg);
                end
            end
            S_UPD:
            begin
                sum_reg <= sum_new;
                cnt_reg <= cnt_new;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    out_acc_reg  <= acc_reg;
                    out_dur_reg  <= dur_reg;
                    out_avg_reg  <= (cnt_reg == '0) ? '0 : AVG_W'(div_quot);
                    out_samp_reg <= SAMP_W'(cnt_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Window memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_UPD)
            window_mem[mark_idx][slot_reg] <= dur_reg;
        old_sample_reg <= window_mem[mark_idx][write_slot_reg[mark_idx]];
    end

    itma_div #(
        .DW (DIVW),
        .VW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({sum_reg, FRAC_W'(0)}),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign busy              = (state_reg != S_IDLE);
    assign done              = done_reg;
    assign accepted          = out_acc_reg;
    assign duration_ns       = out_dur_reg;
    assign average_q8        = out_avg_reg;
    assign samples_in_window = out_samp_reg;

`ifndef SYNTHESIS
    a_done_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_DIV))
        else $error("result strobe without a finished division");

    a_take_request: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    a_duration_only_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        (done && duration_ns != '0) |-> accepted)
        else $error("duration reported on an ignored request");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(samples_in_window) <= WINDOW))
        else $error("window sample count exceeds its size");
`endif

endmodule
